// File: design/cnl_pkg.sv
`timescale 1ns / 1ps

package cnl_pkg;

  localparam int ID_W      = 6;
  localparam int COUNT_W   = 7;
  localparam int ID_SPAN   = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_SELF_LOOPS = 2'd1;

  typedef struct packed {
    logic [ID_W-1:0] source_vertex;
    logic [ID_W-1:0] neighbor;
    logic            neighbor_valid;
    logic            last_neighbor;
  } nbr_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    list_owner;
    logic [ID_W-1:0]    non_neighbor;
    logic               list_empty;
    logic               list_last;
    logic [COUNT_W-1:0] list_length;
  } cmp_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] value;
  } cfg_write_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COUNT,
    ST_COUNT_TAIL,
    ST_EMPTY_OUT,
    ST_WALK_RD,
    ST_WALK_CHK
  } state_t;

endpackage

// File: design/cnl_stream_if.sv
`timescale 1ns / 1ps

interface cnl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/cnl_ram.sv
`timescale 1ns / 1ps

module cnl_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/complement_neighbor_list_top.sv
`timescale 1ns / 1ps
// channel  dir  beat          fields
// nbr_in   in   nbr_item_t    source_vertex, neighbor, neighbor_valid, last_neighbor
// cmp_out  out  cmp_item_t    list_owner, non_neighbor, list_empty, list_last, list_length
// cfg      in   cfg_write_t   index, value (0: vertex_count, 1: allow_self_loops)
//
// A neighbor beat that does not close the list makes at most one write to the seen map.
// A closing beat starts a count pass over the seen map (D entries, D = min(MAX_VERTICES, 64)),
// then a clear-and-emit walk (read, then check, per entry) through the map's single read port.
// Reset starts a clearing pass over the D map entries; no neighbor beat is taken until it ends.
// A stalled output holds the walk; nbr_in.ready is low from the closing beat to the walk's end.

module complement_neighbor_list_top #(
  parameter int MAX_VERTICES = 64
) (
  input logic          clk,
  input logic          rst,
  cnl_stream_if.sink   nbr_in,
  cnl_stream_if.source cmp_out,
  cnl_stream_if.sink   cfg
);

  localparam int DEPTH = (MAX_VERTICES < cnl_pkg::ID_SPAN) ? MAX_VERTICES : cnl_pkg::ID_SPAN;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  cnl_pkg::state_t state, state_next;

  logic [cnl_pkg::COUNT_W-1:0] vertex_count;
  logic                        allow_self_loops;
  logic [AW-1:0]               p, p_next;
  logic [AW-1:0]               chk_addr;
  logic                        count_pend;
  logic [cnl_pkg::ID_W-1:0]    src, src_next;
  logic [cnl_pkg::COUNT_W-1:0] len, len_next;
  logic [cnl_pkg::COUNT_W-1:0] k, k_next;
  logic                        out_valid;
  cnl_pkg::cmp_item_t          out_data, out_data_next;
  logic                        load;

  logic          wr_en, rd_en, wr_data, rd_data;
  logic [AW-1:0] wr_addr;
  logic          in_take, out_free, qual, mark;

  cnl_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_seen (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (p),
    .rd_data (rd_data)
  );

  assign nbr_in.ready  = (state == cnl_pkg::ST_IDLE);
  assign in_take       = nbr_in.valid && nbr_in.ready;
  assign cfg.ready     = 1'b1;
  assign cmp_out.valid = out_valid;
  assign cmp_out.data  = out_data;
  assign out_free      = !out_valid || cmp_out.ready;

  assign mark = nbr_in.data.neighbor_valid
             && ({1'b0, nbr_in.data.neighbor} < vertex_count)
             && ({1'b0, nbr_in.data.neighbor} < cnl_pkg::COUNT_W'(DEPTH));

  assign qual = (cnl_pkg::COUNT_W'(chk_addr) < vertex_count) && !rd_data
             && !((cnl_pkg::COUNT_W'(chk_addr) == {1'b0, src}) && !allow_self_loops);

  always_comb begin
    state_next    = state;
    p_next        = p;
    src_next      = src;
    len_next      = len;
    k_next        = k;
    out_data_next = out_data;
    load          = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = p;
    wr_data       = 1'b0;
    if (count_pend && qual) begin
      len_next = len + 1'b1;
    end
    case (state)
      cnl_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
        if (p == LAST_ADDR) begin
          p_next     = '0;
          state_next = cnl_pkg::ST_IDLE;
        end else begin
          p_next = p + 1'b1;
        end
      end
      cnl_pkg::ST_IDLE: begin
        if (in_take) begin
          if (mark) begin
            wr_en   = 1'b1;
            wr_addr = nbr_in.data.neighbor[AW-1:0];
            wr_data = 1'b1;
          end
          if (nbr_in.data.last_neighbor) begin
            src_next   = nbr_in.data.source_vertex;
            len_next   = '0;
            k_next     = '0;
            p_next     = '0;
            state_next = cnl_pkg::ST_COUNT;
          end
        end
      end
      cnl_pkg::ST_COUNT: begin
        rd_en = 1'b1;
        if (p == LAST_ADDR) begin
          p_next     = '0;
          state_next = cnl_pkg::ST_COUNT_TAIL;
        end else begin
          p_next = p + 1'b1;
        end
      end
      cnl_pkg::ST_COUNT_TAIL: begin
        state_next = (len_next == '0) ? cnl_pkg::ST_EMPTY_OUT : cnl_pkg::ST_WALK_RD;
      end
      cnl_pkg::ST_EMPTY_OUT: begin
        if (out_free) begin
          load                       = 1'b1;
          out_data_next.list_owner   = src;
          out_data_next.non_neighbor = '0;
          out_data_next.list_empty   = 1'b1;
          out_data_next.list_last    = 1'b1;
          out_data_next.list_length  = '0;
          state_next                 = cnl_pkg::ST_WALK_RD;
        end
      end
      cnl_pkg::ST_WALK_RD: begin
        rd_en      = 1'b1;
        wr_en      = 1'b1;
        state_next = cnl_pkg::ST_WALK_CHK;
      end
      cnl_pkg::ST_WALK_CHK: begin
        if (!qual || out_free) begin
          if (qual) begin
            load                       = 1'b1;
            out_data_next.list_owner   = src;
            out_data_next.non_neighbor = cnl_pkg::ID_W'(chk_addr);
            out_data_next.list_empty   = 1'b0;
            out_data_next.list_last    = ((k + 1'b1) == len);
            out_data_next.list_length  = len;
            k_next                     = k + 1'b1;
          end
          if (p == LAST_ADDR) begin
            p_next     = '0;
            state_next = cnl_pkg::ST_IDLE;
          end else begin
            p_next     = p + 1'b1;
            state_next = cnl_pkg::ST_WALK_RD;
          end
        end
      end
      default: begin
        state_next = cnl_pkg::ST_CLEAR;
        p_next     = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cnl_pkg::ST_CLEAR;
      p          <= '0;
      count_pend <= 1'b0;
      out_valid  <= 1'b0;
      len        <= '0;
      k          <= '0;
    end else begin
      state      <= state_next;
      p          <= p_next;
      count_pend <= (state == cnl_pkg::ST_COUNT);
      len        <= len_next;
      k          <= k_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (cmp_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    src      <= src_next;
    out_data <= out_data_next;
    if (rd_en) begin
      chk_addr <= p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count     <= cnl_pkg::COUNT_W'(64);
      allow_self_loops <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.data.index)
        cnl_pkg::CFG_VERTEX_COUNT:     vertex_count     <= cfg.data.value;
        cnl_pkg::CFG_ALLOW_SELF_LOOPS: allow_self_loops <= cfg.data.value[0];
        default: begin
        end
      endcase
    end
  end

  a_close_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_take && nbr_in.data.last_neighbor) |=> !nbr_in.ready)
    else $error("neighbor beat taken right after a closing beat");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> out_free)
    else $error("result register overwritten while still pending");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == cnl_pkg::ST_WALK_CHK) |-> (k <= len))
    else $error("more results emitted than counted");

  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    (load && out_data_next.list_empty) |=> (len == '0) && cmp_out.data.list_last)
    else $error("empty result with nonzero count");

endmodule

// File: sim/tb_complement_neighbor_list_top.sv
`timescale 1ns / 1ps

module tb_complement_neighbor_list_top;

  localparam int MAX_V = 64;
  localparam int SETTLE_CYCLES = 2 * cnl_pkg::ID_SPAN + 24;
  localparam longint TIMEOUT_NS = 2_000_000;

  localparam logic [cnl_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [cnl_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic clk;
  logic rst;

  cnl_stream_if #(.T(cnl_pkg::nbr_item_t))  nbr_if ();
  cnl_stream_if #(.T(cnl_pkg::cmp_item_t))  cmp_if ();
  cnl_stream_if #(.T(cnl_pkg::cfg_write_t)) cfg_if ();

  complement_neighbor_list_top #(
    .MAX_VERTICES(MAX_V)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .nbr_in  (nbr_if),
    .cmp_out (cmp_if),
    .cfg     (cfg_if)
  );

  logic [cnl_pkg::COUNT_W-1:0] cur_vertex_count;
  logic                        cur_self_loops;
  logic [cnl_pkg::ID_SPAN-1:0] marked_ids;
  cnl_pkg::cmp_item_t          pending_complement[$];

  bit bubbles_on;
  int stall_left;
  int errors;
  int beats_sent;
  int lists_closed;
  int complement_beats;
  int regs_written;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout at %0t with %0d complement beats outstanding", $time,
             pending_complement.size());
    $display("status: fail");
    $finish;
  end

  function automatic int live_count();
    int lim;
    lim = cur_vertex_count;
    if (lim > MAX_V) lim = MAX_V;
    if (lim > cnl_pkg::ID_SPAN) lim = cnl_pkg::ID_SPAN;
    return lim;
  endfunction

  // mark the neighbor; on the closing beat queue the complement list and clear the map
  function automatic void fold_neighbor_beat(cnl_pkg::nbr_item_t it);
    int lim;
    int len;
    int k;
    int v;
    cnl_pkg::cmp_item_t r;
    lim = live_count();
    if (it.neighbor_valid && int'(it.neighbor) < lim) marked_ids[it.neighbor] = 1'b1;
    if (!it.last_neighbor) return;
    lists_closed++;
    len = 0;
    for (v = 0; v < lim; v++) begin
      if (!marked_ids[v] && !(v == int'(it.source_vertex) && !cur_self_loops)) len++;
    end
    if (len == 0) begin
      r.list_owner   = it.source_vertex;
      r.non_neighbor = '0;
      r.list_empty   = 1'b1;
      r.list_last    = 1'b1;
      r.list_length  = '0;
      pending_complement.push_back(r);
    end else begin
      k = 0;
      for (v = 0; v < lim; v++) begin
        if (marked_ids[v] || (v == int'(it.source_vertex) && !cur_self_loops)) continue;
        r.list_owner   = it.source_vertex;
        r.non_neighbor = v[cnl_pkg::ID_W-1:0];
        r.list_empty   = 1'b0;
        r.list_last    = (k + 1 == len);
        r.list_length  = len[cnl_pkg::COUNT_W-1:0];
        pending_complement.push_back(r);
        k++;
      end
    end
    marked_ids = '0;
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_complement
    cnl_pkg::cmp_item_t want;
    cnl_pkg::cmp_item_t got;
    if (rst === 1'b0 && cmp_if.valid === 1'b1 && cmp_if.ready === 1'b1) begin
      got = cmp_if.data;
      complement_beats++;
      if (pending_complement.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual owner %0d non_neighbor %0d",
                 $time, got.list_owner, got.non_neighbor);
        errors++;
      end else begin
        want = pending_complement.pop_front();
        check_field("list_owner", want.list_owner, got.list_owner);
        check_field("non_neighbor", want.non_neighbor, got.non_neighbor);
        check_field("list_empty", want.list_empty, got.list_empty);
        check_field("list_last", want.list_last, got.list_last);
        check_field("list_length", want.list_length, got.list_length);
      end
    end
  end

  always @(posedge clk) begin : drive_ready
    if (bubbles_on && stall_left == 0 && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 11);
    if (stall_left > 0) begin
      cmp_if.ready <= 1'b0;
      stall_left--;
    end else begin
      cmp_if.ready <= 1'b1;
    end
  end

  // valid stays high after a beat until the next send or hold_neighbors drives it again
  task automatic send_neighbor(input logic [cnl_pkg::ID_W-1:0] src,
                               input logic [cnl_pkg::ID_W-1:0] nb,
                               input logic nv, input logic lst);
    cnl_pkg::nbr_item_t it;
    it.source_vertex  = src;
    it.neighbor       = nb;
    it.neighbor_valid = nv;
    it.last_neighbor  = lst;
    if (bubbles_on && $urandom_range(0, 3) == 0) begin
      nbr_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    nbr_if.valid <= 1'b1;
    nbr_if.data  <= it;
    @(posedge clk);
    while (nbr_if.ready !== 1'b1) @(posedge clk);
    fold_neighbor_beat(it);
    beats_sent++;
  endtask

  task automatic hold_neighbors();
    nbr_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_complement();
    hold_neighbors();
    while (pending_complement.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cnl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cnl_pkg::CFG_DAT_W-1:0] val);
    cnl_pkg::cfg_write_t w;
    drain_complement();
    repeat (SETTLE_CYCLES) @(posedge clk);
    w.index = idx;
    w.value = val;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      cnl_pkg::CFG_VERTEX_COUNT:     cur_vertex_count = val;
      cnl_pkg::CFG_ALLOW_SELF_LOOPS: cur_self_loops = val[0];
      default: ;
    endcase
    regs_written++;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_neighbor(6'd0, 6'd0, 1'b0, 1'b1);
    send_neighbor(6'd63, 6'd63, 1'b1, 1'b1);
    drain_complement();
  endtask

  task automatic test_tiny_counts();
    write_reg(cnl_pkg::CFG_VERTEX_COUNT, 7'd1);
    send_neighbor(6'd0, 6'd0, 1'b0, 1'b1);
    write_reg(cnl_pkg::CFG_ALLOW_SELF_LOOPS, 7'd1);
    send_neighbor(6'd0, 6'd0, 1'b0, 1'b1);
    send_neighbor(6'd0, 6'd0, 1'b1, 1'b1);
    write_reg(cnl_pkg::CFG_VERTEX_COUNT, 7'd0);
    send_neighbor(6'd5, 6'd5, 1'b1, 1'b1);
  endtask

  task automatic test_repeats_and_range();
    write_reg(cnl_pkg::CFG_ALLOW_SELF_LOOPS, 7'd0);
    write_reg(cnl_pkg::CFG_VERTEX_COUNT, 7'd6);
    send_neighbor(6'd2, 6'd4, 1'b1, 1'b0);
    send_neighbor(6'd2, 6'd4, 1'b1, 1'b0);
    send_neighbor(6'd2, 6'd9, 1'b1, 1'b0);
    send_neighbor(6'd2, 6'd1, 1'b0, 1'b0);
    send_neighbor(6'd3, 6'd5, 1'b1, 1'b1);
    send_neighbor(6'd40, 6'd0, 1'b1, 1'b1);
    write_reg(cnl_pkg::CFG_ALLOW_SELF_LOOPS, 7'd1);
    send_neighbor(6'd2, 6'd2, 1'b0, 1'b1);
  endtask

  task automatic test_wide_count();
    write_reg(cnl_pkg::CFG_ALLOW_SELF_LOOPS, 7'd0);
    write_reg(cnl_pkg::CFG_VERTEX_COUNT, 7'd127);
    send_neighbor(6'd10, 6'd63, 1'b1, 1'b0);
    send_neighbor(6'd10, 6'd0, 1'b1, 1'b1);
    write_reg(cnl_pkg::CFG_VERTEX_COUNT, 7'd65);
    send_neighbor(6'd31, 6'd32, 1'b1, 1'b1);
  endtask

  task automatic test_count_change_midlist();
    write_reg(cnl_pkg::CFG_VERTEX_COUNT, 7'd64);
    send_neighbor(6'd1, 6'd40, 1'b1, 1'b0);
    send_neighbor(6'd1, 6'd3, 1'b1, 1'b0);
    write_reg(cnl_pkg::CFG_VERTEX_COUNT, 7'd8);
    send_neighbor(6'd1, 6'd5, 1'b1, 1'b1);
    write_reg(cnl_pkg::CFG_VERTEX_COUNT, 7'd64);
    send_neighbor(6'd1, 6'd0, 1'b0, 1'b1);
  endtask

  task automatic test_spare_and_masked_regs();
    write_reg(CFG_SPARE_A, 7'h7F);
    write_reg(CFG_SPARE_B, 7'h55);
    write_reg(cnl_pkg::CFG_ALLOW_SELF_LOOPS, 7'h7E);
    write_reg(cnl_pkg::CFG_VERTEX_COUNT, 7'd5);
    send_neighbor(6'd4, 6'd0, 1'b0, 1'b1);
    write_reg(cnl_pkg::CFG_ALLOW_SELF_LOOPS, 7'h03);
    send_neighbor(6'd4, 6'd0, 1'b0, 1'b1);
  endtask

  task automatic send_random_list(output int sent);
    int lim;
    int extra;
    logic [cnl_pkg::ID_W-1:0] src;
    logic [cnl_pkg::ID_W-1:0] nb;
    lim = live_count();
    extra = $urandom_range(0, 5);
    sent = 0;
    if (lim > 0 && $urandom_range(0, 3) != 0) src = cnl_pkg::ID_W'($urandom_range(0, lim - 1));
    else src = cnl_pkg::ID_W'($urandom_range(0, 63));
    for (int i = 0; i <= extra; i++) begin
      if (lim > 0 && $urandom_range(0, 5) != 0) nb = cnl_pkg::ID_W'($urandom_range(0, lim - 1));
      else nb = cnl_pkg::ID_W'($urandom_range(0, 63));
      if (i == extra && $urandom_range(0, 9) == 0) src = cnl_pkg::ID_W'($urandom_range(0, 63));
      send_neighbor(src, nb, $urandom_range(0, 7) != 0, i == extra);
      sent++;
    end
  endtask

  task automatic test_random_lists();
    int phase_items;
    int sent;
    logic [cnl_pkg::COUNT_W-1:0] cnt;
    for (int phase = 0; phase < 4; phase++) begin
      case ($urandom_range(0, 5))
        0: cnt = 7'd1;
        1: cnt = 7'd64;
        2: cnt = cnl_pkg::COUNT_W'($urandom_range(65, 127));
        3: cnt = cnl_pkg::COUNT_W'($urandom_range(0, 3));
        default: cnt = cnl_pkg::COUNT_W'($urandom_range(2, 24));
      endcase
      write_reg(cnl_pkg::CFG_VERTEX_COUNT, cnt);
      write_reg(cnl_pkg::CFG_ALLOW_SELF_LOOPS, cnl_pkg::CFG_DAT_W'($urandom_range(0, 127)));
      phase_items = 0;
      while (phase_items < 22) begin
        if (phase == 3) bubbles_on = 1'b0;
        else if (phase == 2) bubbles_on = $urandom_range(0, 1);
        else bubbles_on = 1'b1;
        send_random_list(sent);
        phase_items += sent;
        if (phase < 3 && $urandom_range(0, 7) == 0) drain_complement();
      end
    end
  endtask

  initial begin
    rst           <= 1'b1;
    nbr_if.valid  <= 1'b0;
    nbr_if.data   <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.data   <= '0;
    cur_vertex_count = 7'd64;
    cur_self_loops   = 1'b0;
    marked_ids       = '0;
    bubbles_on       = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_tiny_counts();
    test_repeats_and_range();
    test_wide_count();
    test_count_change_midlist();
    test_spare_and_masked_regs();
    test_random_lists();

    drain_complement();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d neighbor beats in %0d lists, %0d complement beats, %0d reg writes",
             beats_sent, lists_closed, complement_beats, regs_written);
    $display("counts from 0 to 127, self loops on and off, mismatches seen: %0d", errors);
    if (errors == 0 && pending_complement.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
